FILE: hdl/mkd_pkg.sv
`timescale 1ns / 1ps
// Package for the Morse key decoder: event codes, register indexes, widths
// and the letter table with its lookup function. No dependencies.
package mkd_pkg;

   localparam int TICK_W    = 8;
   localparam int CODE_W    = 8;
   localparam int ELEM_W    = 4;
   localparam int LETTER_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int LETTER_NUM = 26;

   localparam logic [ELEM_W-1:0] ELEM_MAX = 4'd8;
   localparam logic [TICK_W-1:0] TICK_SAT = 8'hFF;

   localparam logic [TICK_W-1:0] DOT_MIN_RESET  = 8'd2;
   localparam logic [TICK_W-1:0] DASH_MIN_RESET = 8'd5;
   localparam logic [TICK_W-1:0] GAP_RESET      = 8'd12;

   typedef enum logic [1:0] {
      EV_DOT     = 2'd0,
      EV_DASH    = 2'd1,
      EV_LETTER  = 2'd2,
      EV_UNKNOWN = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOT_MIN  = 2'd0,
      CSR_DASH_MIN = 2'd1,
      CSR_GAP      = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   typedef struct packed {
      event_type             ev;
      logic [LETTER_W-1:0]   letter;
   } result_word_type;

   typedef struct packed {
      logic [LETTER_W-1:0] ch;
      logic [CODE_W-1:0]   pattern;
      logic [ELEM_W-1:0]   count;
   } letter_entry_type;

   // Pattern holds the first element in the most significant used bit; 1 is a dash.
   localparam letter_entry_type LETTER_TAB [LETTER_NUM] = '{
      '{7'h61, 8'h01, 4'd2}, '{7'h62, 8'h08, 4'd4}, '{7'h63, 8'h0A, 4'd4},
      '{7'h64, 8'h04, 4'd3}, '{7'h65, 8'h00, 4'd1}, '{7'h66, 8'h02, 4'd4},
      '{7'h67, 8'h06, 4'd3}, '{7'h68, 8'h00, 4'd4}, '{7'h69, 8'h00, 4'd2},
      '{7'h6A, 8'h07, 4'd4}, '{7'h6B, 8'h05, 4'd3}, '{7'h6C, 8'h04, 4'd4},
      '{7'h6D, 8'h03, 4'd2}, '{7'h6E, 8'h02, 4'd2}, '{7'h6F, 8'h07, 4'd3},
      '{7'h70, 8'h06, 4'd4}, '{7'h71, 8'h0D, 4'd4}, '{7'h72, 8'h02, 4'd3},
      '{7'h73, 8'h00, 4'd3}, '{7'h74, 8'h01, 4'd1}, '{7'h75, 8'h01, 4'd3},
      '{7'h76, 8'h01, 4'd4}, '{7'h77, 8'h03, 4'd3}, '{7'h78, 8'h09, 4'd4},
      '{7'h79, 8'h0B, 4'd4}, '{7'h7A, 8'h0C, 4'd4}
   };

   // Returns the letter for a code, or zero when no entry matches.
   function automatic logic [LETTER_W-1:0] lookup_letter(
      input logic [CODE_W-1:0] pattern,
      input logic [ELEM_W-1:0] count
   );
      logic [LETTER_W-1:0] ch;
      ch = '0;
      for (int i = 0; i < LETTER_NUM; i++) begin
         if (LETTER_TAB[i].count == count && LETTER_TAB[i].pattern == pattern) begin
            ch = LETTER_TAB[i].ch;
         end
      end
      return ch;
   endfunction

endpackage

FILE: hdl/mkd_core.sv
`timescale 1ns / 1ps
// Decoder core: timing registers, press and gap counters, code register and
// the per-tick classification. Depends on mkd_pkg.
module mkd_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mkd_pkg::TICK_W-1:0]     csr_wdata,
   input  logic                           tick_fire,
   input  logic                           key_down,
   output logic                           res_valid,
   output mkd_pkg::result_word_type       res_word
);
   import mkd_pkg::*;

   logic [TICK_W-1:0] dot_min_ff, dot_min_in;
   logic [TICK_W-1:0] dash_min_ff, dash_min_in;
   logic [TICK_W-1:0] gap_ticks_ff, gap_ticks_in;
   logic [TICK_W-1:0] held_ff, held_in;
   logic [TICK_W-1:0] gap_ff, gap_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic              last_key_ff, last_key_in;

   logic              is_dash;
   logic [TICK_W-1:0] gap_next;
   logic [LETTER_W-1:0] found;

   always_comb begin
      dot_min_in  = dot_min_ff;
      dash_min_in = dash_min_ff;
      gap_ticks_in = gap_ticks_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DOT_MIN:  dot_min_in   = csr_wdata;
            CSR_DASH_MIN: dash_min_in  = csr_wdata;
            CSR_GAP:      gap_ticks_in = csr_wdata;
            default:      ;
         endcase
      end
   end

   assign is_dash  = (held_ff >= dash_min_ff);
   assign gap_next = (gap_ff != TICK_SAT) ? gap_ff + 8'd1 : gap_ff;
   assign found    = lookup_letter(code_ff, elem_ff);

   always_comb begin
      held_in     = held_ff;
      gap_in      = gap_ff;
      code_in     = code_ff;
      elem_in     = elem_ff;
      last_key_in = last_key_ff;
      res_valid   = 1'b0;
      res_word.ev     = EV_DOT;
      res_word.letter = '0;
      if (tick_fire) begin
         last_key_in = key_down;
         if (key_down) begin
            if (held_ff != TICK_SAT) begin
               held_in = held_ff + 8'd1;
            end
            gap_in = '0;
         end else if (last_key_ff) begin
            held_in = '0;
            gap_in  = '0;
            if (is_dash || held_ff >= dot_min_ff) begin
               code_in = {code_ff[CODE_W-2:0], is_dash};
               if (elem_ff < ELEM_MAX) begin
                  elem_in = elem_ff + 4'd1;
               end
               res_valid   = 1'b1;
               res_word.ev = is_dash ? EV_DASH : EV_DOT;
            end
         end else if (elem_ff != '0) begin
            gap_in = gap_next;
            if (gap_next >= gap_ticks_ff) begin
               res_valid = 1'b1;
               if (found != '0) begin
                  res_word.ev     = EV_LETTER;
                  res_word.letter = found;
               end else begin
                  res_word.ev = EV_UNKNOWN;
               end
               code_in = '0;
               elem_in = '0;
               gap_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_min_ff   <= DOT_MIN_RESET;
         dash_min_ff  <= DASH_MIN_RESET;
         gap_ticks_ff <= GAP_RESET;
         held_ff      <= '0;
         gap_ff       <= '0;
         code_ff      <= '0;
         elem_ff      <= '0;
         last_key_ff  <= 1'b0;
      end else begin
         dot_min_ff   <= dot_min_in;
         dash_min_ff  <= dash_min_in;
         gap_ticks_ff <= gap_ticks_in;
         held_ff      <= held_in;
         gap_ff       <= gap_in;
         code_ff      <= code_in;
         elem_ff      <= elem_in;
         last_key_ff  <= last_key_in;
      end
   end

endmodule

FILE: hdl/mkd_out_buf.sv
`timescale 1ns / 1ps
// Result register with a skid entry, so that the next tick is taken while a
// result word waits. Depends on mkd_pkg.
module mkd_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mkd_pkg::result_word_type push_word,
   output logic                     space,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mkd_pkg::result_word_type out_word
);
   import mkd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   result_word_type main_ff, main_in;
   result_word_type skid_ff, skid_in;
   logic            pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = push_word;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: hdl/morse_key_decoder.sv
`timescale 1ns / 1ps
//  Channel   Ports                                   Direction
//  req       req_valid, req_ready, req_key_down      in  (one key sample a word)
//  rsp       rsp_valid, rsp_ready, rsp_event_type,   out (dot, dash, letter, unknown)
//            rsp_letter
//  csr       csr_we, csr_index, csr_wdata            in  (timing registers)
// A sample is taken every cycle while req_valid and req_ready are high; its result word is registered.
// A result waits in the output register while a skid entry still takes a further sample,
// so req_ready falls only when both hold a word.
// Reset is synchronous and restores the timing registers to 2, 5 and 12 ticks.
// Top level of the Morse key decoder; depends on mkd_pkg, mkd_core, mkd_out_buf.
module morse_key_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_key_down,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_event_type,
   output logic [mkd_pkg::LETTER_W-1:0]  rsp_letter,
   input  logic                          csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mkd_pkg::TICK_W-1:0]    csr_wdata
);
   import mkd_pkg::*;

   logic            fire;
   logic            res_valid;
   logic            space;
   result_word_type res_word;
   result_word_type out_word;

   assign req_ready = space;
   assign fire      = req_valid && space;

   mkd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tick_fire (fire),
      .key_down  (req_key_down),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   mkd_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_event_type = out_word.ev;
   assign rsp_letter     = out_word.letter;

endmodule

FILE: hdl/mkd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg and morse_key_decoder.
module mkd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_event_type,
   input logic [mkd_pkg::LETTER_W-1:0]  rsp_letter
);
   import mkd_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input stalled after reset");

   a_letter_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_type == EV_LETTER) == (rsp_letter != '0)))
      else $error("letter field does not match the event type");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_type == EV_LETTER) |->
         (rsp_letter >= 7'h61 && rsp_letter <= 7'h7A))
      else $error("decoded letter outside a to z");

   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      (!req_ready && rsp_valid && rsp_ready) |=> req_ready)
      else $error("input still stalled after a word was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_event_type) && $stable(rsp_letter)))
      else $error("result word changed while stalled");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_type (rsp_event_type),
   .rsp_letter     (rsp_letter)
);

FILE: test/morse_event_checker.sv
`timescale 1ns / 1ps
// Result checker for the Morse key decoder testbench: follows the timing registers,
// predicts the event word for every accepted key sample and compares each result word.
// Depends on mkd_pkg.
module morse_event_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_key_down,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_event_type,
   input  logic [mkd_pkg::LETTER_W-1:0]  rsp_letter,
   input  logic                          csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mkd_pkg::TICK_W-1:0]    csr_wdata,
   output int                            mismatch_count,
   output int                            words_pending
);
   import mkd_pkg::*;

   logic [TICK_W-1:0] dot_min;
   logic [TICK_W-1:0] dash_min;
   logic [TICK_W-1:0] gap_len;
   logic [TICK_W-1:0] held;
   logic [TICK_W-1:0] gap_run;
   logic [CODE_W-1:0] code;
   logic [ELEM_W-1:0] elems;
   logic              key_was;
   result_word_type   expected_events[$];

   // The code holds the first element in its most significant used bit; a dash is 1.
   function automatic logic [7:0] morse_letter(input logic [CODE_W-1:0] pattern,
                                               input logic [ELEM_W-1:0] count);
      logic [7:0] ascii;
      case ({count, pattern})
         {4'd2, 8'b01}:   ascii = "a";
         {4'd4, 8'b1000}: ascii = "b";
         {4'd4, 8'b1010}: ascii = "c";
         {4'd3, 8'b100}:  ascii = "d";
         {4'd1, 8'b0}:    ascii = "e";
         {4'd4, 8'b0010}: ascii = "f";
         {4'd3, 8'b110}:  ascii = "g";
         {4'd4, 8'b0000}: ascii = "h";
         {4'd2, 8'b00}:   ascii = "i";
         {4'd4, 8'b0111}: ascii = "j";
         {4'd3, 8'b101}:  ascii = "k";
         {4'd4, 8'b0100}: ascii = "l";
         {4'd2, 8'b11}:   ascii = "m";
         {4'd2, 8'b10}:   ascii = "n";
         {4'd3, 8'b111}:  ascii = "o";
         {4'd4, 8'b0110}: ascii = "p";
         {4'd4, 8'b1101}: ascii = "q";
         {4'd3, 8'b010}:  ascii = "r";
         {4'd3, 8'b000}:  ascii = "s";
         {4'd1, 8'b1}:    ascii = "t";
         {4'd3, 8'b001}:  ascii = "u";
         {4'd4, 8'b0001}: ascii = "v";
         {4'd3, 8'b011}:  ascii = "w";
         {4'd4, 8'b1001}: ascii = "x";
         {4'd4, 8'b1011}: ascii = "y";
         {4'd4, 8'b1100}: ascii = "z";
         default:         ascii = 8'd0;
      endcase
      return ascii;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic decode_tick(input logic down);
      logic [TICK_W-1:0] press;
      logic              dash;
      logic [7:0]        ascii;
      result_word_type   word;
      word.letter = '0;
      if (down) begin
         if (held != TICK_SAT) held++;
         gap_run = '0;
      end else if (key_was) begin
         press   = held;
         held    = '0;
         gap_run = '0;
         if (press >= dash_min || press >= dot_min) begin
            dash = (press >= dash_min);
            code = {code[CODE_W-2:0], dash};
            if (elems < ELEM_MAX) elems++;
            word.ev = dash ? EV_DASH : EV_DOT;
            expected_events.push_back(word);
         end
      end else if (elems != 0) begin
         if (gap_run != TICK_SAT) gap_run++;
         if (gap_run >= gap_len) begin
            ascii = morse_letter(code, elems);
            if (ascii != 0) begin
               word.ev     = EV_LETTER;
               word.letter = ascii[LETTER_W-1:0];
            end else begin
               word.ev = EV_UNKNOWN;
            end
            expected_events.push_back(word);
            code    = '0;
            elems   = '0;
            gap_run = '0;
         end
      end
      key_was = down;
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         dot_min  = DOT_MIN_RESET;
         dash_min = DASH_MIN_RESET;
         gap_len  = GAP_RESET;
         held     = '0;
         gap_run  = '0;
         code     = '0;
         elems    = '0;
         key_was  = 1'b0;
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("result word with none expected", rsp_event_type, -1);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_type !== want.ev) begin
                  report_mismatch("event type", rsp_event_type, want.ev);
               end
               if (rsp_letter !== want.letter) begin
                  report_mismatch("letter", rsp_letter, want.letter);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DOT_MIN:  dot_min  = csr_wdata;
               CSR_DASH_MIN: dash_min = csr_wdata;
               CSR_GAP:      gap_len  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) decode_tick(req_key_down);
      end
      words_pending = expected_events.size();
   end

endmodule

FILE: test/morse_key_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the Morse key decoder: drives key samples, timing register writes
// and result back-pressure, and gives the verdict. Depends on mkd_pkg,
// morse_key_decoder and morse_event_checker.
module morse_key_decoder_tb;
   import mkd_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_TICKS = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_key_down = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_event_type;
   logic [LETTER_W-1:0]  rsp_letter;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DOT_MIN;
   logic [TICK_W-1:0]    csr_wdata = '0;

   int mismatch_count;
   int words_pending;
   bit idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   int ticks_sent;
   int cfg_dot = DOT_MIN_RESET;
   int cfg_dash = DASH_MIN_RESET;
   int cfg_gap = GAP_RESET;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   morse_key_decoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_down   (req_key_down),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_type (rsp_event_type),
      .rsp_letter     (rsp_letter),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   morse_event_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_down   (req_key_down),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_type (rsp_event_type),
      .rsp_letter     (rsp_letter),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   task automatic send_tick(input logic level);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_down <= level;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic key_run(input logic level, input int count);
      repeat (count) send_tick(level);
   endtask

   task automatic write_timing(input int dot, input int dash, input int gap);
      csr_we    <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= 8'($urandom_range(0, 255));
      @(posedge clock);
      csr_index <= CSR_DOT_MIN;
      csr_wdata <= dot[TICK_W-1:0];
      @(posedge clock);
      csr_index <= CSR_DASH_MIN;
      csr_wdata <= dash[TICK_W-1:0];
      @(posedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= gap[TICK_W-1:0];
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_dot  = dot;
      cfg_dash = dash;
      cfg_gap  = gap;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_letter(input int elements, input bit finish_letter);
      int eff_gap;
      int dot_lo;
      int dot_hi;
      int dash_lo;
      int ign_hi;
      int pick;
      int press;
      eff_gap = (cfg_gap == 0) ? 1 : cfg_gap;
      dot_lo  = (cfg_dot == 0) ? 1 : cfg_dot;
      dot_hi  = cfg_dash - 1;
      dash_lo = (cfg_dash == 0) ? 1 : cfg_dash;
      ign_hi  = ((cfg_dot < cfg_dash) ? cfg_dot : cfg_dash) - 1;
      repeat (elements) begin
         pick = $urandom_range(0, 9);
         if (pick == 0 && ign_hi >= 1) press = $urandom_range(1, ign_hi);
         else if (pick < 5 && dot_hi >= dot_lo) press = $urandom_range(dot_lo, dot_hi);
         else if (pick == 9) press = $urandom_range(1, dash_lo + 6);
         else press = $urandom_range(dash_lo, dash_lo + 3);
         key_run(1'b1, press);
         key_run(1'b0, $urandom_range(1, eff_gap));
      end
      if (finish_letter) key_run(1'b0, $urandom_range(eff_gap, eff_gap + 2));
   endtask

   task automatic random_phase();
      ticks_sent = 0;
      while (ticks_sent < PHASE_TICKS) begin
         if ($urandom_range(0, 9) == 0) begin
            key_run(1'($urandom_range(0, 1)), $urandom_range(1, 6));
         end else begin
            send_letter(($urandom_range(0, 7) == 0) ? $urandom_range(5, 10)
                                                   : $urandom_range(1, 4),
                        $urandom_range(0, 7) != 0);
         end
      end
      drain();
   endtask

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      key_run(1'b0, 3);
      key_run(1'b1, 1);
      key_run(1'b0, 14);
      key_run(1'b1, 2);
      key_run(1'b0, 13);
      key_run(1'b1, 4);
      key_run(1'b0, 12);
      key_run(1'b1, 5);
      key_run(1'b0, 13);
      key_run(1'b1, 3);
      key_run(1'b0, 5);
      key_run(1'b1, 1);
      key_run(1'b0, 13);
      repeat (4) begin
         key_run(1'b1, 2);
         key_run(1'b0, 2);
      end
      key_run(1'b0, 11);
      repeat (9) begin
         key_run(1'b1, 2);
         key_run(1'b0, 1);
      end
      key_run(1'b0, 13);
      drain();

      // The long receiver hold-off lets result words pile up until samples are refused.
      write_timing(1, 2, 2);
      hold_rsp = 1'b1;
      repeat (30) begin
         key_run(1'b1, 1);
         key_run(1'b0, 1);
      end
      key_run(1'b0, 3);
      random_phase();

      write_timing(3, 6, 4);
      random_phase();
      write_timing(6, 3, 3);
      random_phase();
      write_timing(255, 255, 8);
      key_run(1'b1, 258);
      key_run(1'b0, 10);
      drain();
      write_timing(0, 0, 0);
      random_phase();

      idle_on = 1'b0;
      write_timing(DOT_MIN_RESET, DASH_MIN_RESET, GAP_RESET);
      random_phase();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/mkd_pkg.sv
hdl/mkd_core.sv
hdl/mkd_out_buf.sv
hdl/morse_key_decoder.sv
hdl/mkd_checker.sv
test/morse_event_checker.sv
test/morse_key_decoder_tb.sv
